// ===== hw/rtl/aopb_pkg.sv =====
// Package for the alpha-over pixel blender: component widths, item structs,
// register indexes and field/component conversion helpers. No dependencies.
package aopb_pkg;

    localparam int COMP_BITS  = 8;
    localparam int FIELD_W    = 8;
    localparam int WIDE_W     = 2 * COMP_BITS;
    localparam int NUM_W      = 3 * COMP_BITS;
    localparam int PIPE_DEPTH = COMP_BITS + 3;
    localparam int CFG_IDX_W  = 2;

    typedef logic [COMP_BITS-1:0] t_comp;
    typedef logic [WIDE_W-1:0]    t_wide;
    typedef logic [NUM_W-1:0]     t_num;
    typedef logic [FIELD_W-1:0]   t_field;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_wide COMP_MAX = t_wide'((64'd1 << COMP_BITS) - 64'd1);

    localparam t_cfg_idx CFG_BLEND_ENABLE     = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_THREE_COMPONENTS = t_cfg_idx'(1);

    typedef struct packed {
        t_field src_x;
        t_field src_y;
        t_field src_z;
        t_field src_a;
        t_field dst_x;
        t_field dst_y;
        t_field dst_z;
        t_field dst_a;
    } t_in;

    typedef struct packed {
        t_field out_x;
        t_field out_y;
        t_field out_z;
        t_field out_a;
    } t_out;

    typedef struct packed {
        t_wide wi;
        t_wide wo;
        t_wide a;
    } t_wgt;

    typedef struct packed {
        logic blend_enable;
        logic three_components;
    } t_cfg;

    function automatic t_comp to_comp(t_field f);
        logic [FIELD_W+COMP_BITS-1:0] w;
        w = {{COMP_BITS{1'b0}}, f};
        return w[COMP_BITS-1:0];
    endfunction

    function automatic t_field to_field(t_comp c);
        logic [FIELD_W+COMP_BITS-1:0] w;
        w = {{FIELD_W{1'b0}}, c};
        return w[FIELD_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/aopb_weight.sv =====
// Weight stage: source/destination weights and combined alpha, registered.
// Depends on aopb_pkg.
module aopb_weight (
    input  logic          i_clk,
    input  aopb_pkg::t_in i_data,
    output aopb_pkg::t_wgt o_wgt
);

    aopb_pkg::t_wgt r_wgt;
    aopb_pkg::t_wgt n_wgt;

    always_comb begin
        aopb_pkg::t_comp sa;
        aopb_pkg::t_comp da;
        aopb_pkg::t_comp inv;
        sa  = aopb_pkg::to_comp(i_data.src_a);
        da  = aopb_pkg::to_comp(i_data.dst_a);
        inv = aopb_pkg::COMP_MAX[aopb_pkg::COMP_BITS-1:0] - sa;
        n_wgt.wi = aopb_pkg::t_wide'(sa) * aopb_pkg::COMP_MAX;
        n_wgt.wo = aopb_pkg::t_wide'(da) * aopb_pkg::t_wide'(inv);
        n_wgt.a  = n_wgt.wi + n_wgt.wo;
    end

    always_ff @(posedge i_clk) begin
        r_wgt <= n_wgt;
    end

    assign o_wgt = r_wgt;

endmodule

// ===== hw/rtl/aopb_lane.sv =====
// One blend lane: weighted products, numerator sum, then a pipelined
// restoring divider giving one quotient bit per stage. Depends on aopb_pkg.
module aopb_lane (
    input  logic             i_clk,
    input  aopb_pkg::t_comp  i_s,
    input  aopb_pkg::t_comp  i_d,
    input  aopb_pkg::t_wgt   i_wgt,
    input  aopb_pkg::t_wide  i_den,
    output aopb_pkg::t_comp  o_q
);

    localparam int CB = aopb_pkg::COMP_BITS;

    aopb_pkg::t_num  r_ps;
    aopb_pkg::t_num  r_pd;
    aopb_pkg::t_wide r_den_p;

    aopb_pkg::t_num  r_rem [0:CB-1];
    aopb_pkg::t_wide r_den [0:CB];
    aopb_pkg::t_comp r_quo [1:CB];

    always_ff @(posedge i_clk) begin
        r_ps     <= aopb_pkg::t_num'(i_s) * aopb_pkg::t_num'(i_wgt.wi);
        r_pd     <= aopb_pkg::t_num'(i_d) * aopb_pkg::t_num'(i_wgt.wo);
        r_den_p  <= i_den;
        r_rem[0] <= r_ps + r_pd;
        r_den[0] <= r_den_p;
    end

    for (genvar i = 0; i < CB; i++) begin : g_div
        localparam int K = CB - 1 - i;
        aopb_pkg::t_num  w_sh;
        aopb_pkg::t_comp w_qin;
        logic            w_ge;

        if (i == 0) begin : g_q0
            assign w_qin = '0;
        end else begin : g_qn
            assign w_qin = r_quo[i];
        end

        assign w_sh = aopb_pkg::t_num'(r_den[i]) << K;
        assign w_ge = r_rem[i] >= w_sh;

        always_ff @(posedge i_clk) begin
            r_den[i+1] <= r_den[i];
            r_quo[i+1] <= w_qin | (w_ge ? aopb_pkg::t_comp'(1) << K : '0);
        end

        if (i < CB - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                r_rem[i+1] <= w_ge ? r_rem[i] - w_sh : r_rem[i];
            end
        end
    end

    // zero divisor means both alphas were zero
    assign o_q = (r_den[CB] == '0) ? '0 : r_quo[CB];

endmodule

// ===== hw/rtl/aopb_merge.sv =====
// Merge stage: picks lane quotients or pass-through fields per mode and
// registers the result item. Depends on aopb_pkg.
module aopb_merge (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_vld,
    input  aopb_pkg::t_in   i_side,
    input  aopb_pkg::t_cfg  i_cfg,
    input  aopb_pkg::t_comp i_qx,
    input  aopb_pkg::t_comp i_qy,
    input  aopb_pkg::t_comp i_qz,
    input  aopb_pkg::t_comp i_qa,
    output logic            o_valid,
    output aopb_pkg::t_out  o_data
);

    logic           r_valid;
    aopb_pkg::t_out r_out;
    aopb_pkg::t_out n_out;

    always_comb begin
        aopb_pkg::t_comp cx;
        aopb_pkg::t_comp cy;
        aopb_pkg::t_comp cz;
        aopb_pkg::t_comp ca;
        if (i_cfg.blend_enable) begin
            cx = i_qx;
            cy = i_qy;
            cz = i_qz;
            ca = i_qa;
        end else begin
            cx = aopb_pkg::to_comp(i_side.src_x);
            cy = aopb_pkg::to_comp(i_side.src_y);
            cz = aopb_pkg::to_comp(i_side.src_z);
            ca = aopb_pkg::to_comp(i_side.dst_a);
        end
        if (!i_cfg.three_components) begin
            cy = aopb_pkg::to_comp(i_side.dst_y);
            cz = aopb_pkg::to_comp(i_side.dst_z);
        end
        n_out.out_x = aopb_pkg::to_field(cx);
        n_out.out_y = aopb_pkg::to_field(cy);
        n_out.out_z = aopb_pkg::to_field(cz);
        n_out.out_a = aopb_pkg::to_field(ca);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_vld;
        end
        r_out <= n_out;
    end

    assign o_valid = r_valid;
    assign o_data  = r_out;

endmodule

// ===== hw/rtl/alpha_over_pixel_blend_top.sv =====
// Top level of the straight-alpha over pixel blender.
// Depends on aopb_pkg, aopb_weight, aopb_lane, aopb_merge.
//
// Usage:
//   Input channel: drive i_data and raise i_start; the item is taken at a
//   clock edge where i_start is high and o_busy is low. o_busy is high only
//   during reset and the cycle after it, so one item per clock is taken.
//   Output: o_valid marks o_data for one cycle; there is no stall input and
//   results must be taken when shown.
//   Pipeline: from the accepting edge to the result, the registers in order
//   are weights, products, numerator sum, one stage per quotient bit of the
//   divider, and the output register.
//   Throughput: one item per clock; three component lanes run in parallel,
//   each with a fully pipelined divider. Output alpha is the combined alpha
//   over the constant maximum, done by shift-add and delayed to match.
//   Config channel: i_cfg_valid/o_cfg_ready with i_cfg_index and
//   i_cfg_data; index 0 is blend_enable, index 1 is three_components,
//   others are ignored. Write only while no items are in flight.
//   Reset: synchronous, active low; both config bits return to 1 and all
//   items in flight are dropped.
module alpha_over_pixel_blend_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    output logic               o_busy,
    input  aopb_pkg::t_in      i_data,
    output logic               o_valid,
    output aopb_pkg::t_out     o_data,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  aopb_pkg::t_cfg_idx i_cfg_index,
    input  logic               i_cfg_data
);

    localparam int DEPTH = aopb_pkg::PIPE_DEPTH;

    logic                     r_busy;
    logic                     r_cfg_ready;
    aopb_pkg::t_cfg           r_cfg;
    logic [DEPTH-1:0]         r_vld;
    aopb_pkg::t_in            r_side [0:DEPTH-1];
    aopb_pkg::t_comp          r_qa [1:DEPTH-1];
    logic                     w_accept;
    aopb_pkg::t_wgt           w_wgt;
    aopb_pkg::t_wide          w_qa_sum;
    aopb_pkg::t_comp          w_qx;
    aopb_pkg::t_comp          w_qy;
    aopb_pkg::t_comp          w_qz;
    aopb_pkg::t_comp          w_qa;

    assign w_accept = i_start && !r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy                 <= 1'b1;
            r_cfg_ready            <= 1'b0;
            r_cfg.blend_enable     <= 1'b1;
            r_cfg.three_components <= 1'b1;
            r_vld                  <= '0;
        end else begin
            r_busy      <= 1'b0;
            r_cfg_ready <= 1'b1;
            r_vld       <= {r_vld[DEPTH-2:0], w_accept};
            if (i_cfg_valid && r_cfg_ready) begin
                unique case (i_cfg_index)
                    aopb_pkg::CFG_BLEND_ENABLE:     r_cfg.blend_enable <= i_cfg_data;
                    aopb_pkg::CFG_THREE_COMPONENTS: r_cfg.three_components <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_side[0] <= i_data;
        for (int i = 1; i < DEPTH; i++) begin
            r_side[i] <= r_side[i-1];
        end
    end

    aopb_weight u_weight (
        .i_clk  (i_clk),
        .i_data (i_data),
        .o_wgt  (w_wgt)
    );

    aopb_lane u_lane_x (
        .i_clk (i_clk),
        .i_s   (aopb_pkg::to_comp(r_side[0].src_x)),
        .i_d   (aopb_pkg::to_comp(r_side[0].dst_x)),
        .i_wgt (w_wgt),
        .i_den (w_wgt.a),
        .o_q   (w_qx)
    );

    aopb_lane u_lane_y (
        .i_clk (i_clk),
        .i_s   (aopb_pkg::to_comp(r_side[0].src_y)),
        .i_d   (aopb_pkg::to_comp(r_side[0].dst_y)),
        .i_wgt (w_wgt),
        .i_den (w_wgt.a),
        .o_q   (w_qy)
    );

    aopb_lane u_lane_z (
        .i_clk (i_clk),
        .i_s   (aopb_pkg::to_comp(r_side[0].src_z)),
        .i_d   (aopb_pkg::to_comp(r_side[0].dst_z)),
        .i_wgt (w_wgt),
        .i_den (w_wgt.a),
        .o_q   (w_qz)
    );

    // a / M is exact as (a + 1 + (a >> COMP_BITS)) >> COMP_BITS for a <= M*M
    assign w_qa_sum = w_wgt.a + aopb_pkg::t_wide'(1)
                    + (w_wgt.a >> aopb_pkg::COMP_BITS);

    always_ff @(posedge i_clk) begin
        r_qa[1] <= w_qa_sum[aopb_pkg::WIDE_W-1:aopb_pkg::COMP_BITS];
        for (int i = 2; i < DEPTH; i++) begin
            r_qa[i] <= r_qa[i-1];
        end
    end

    assign w_qa = r_qa[DEPTH-1];

    aopb_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_vld[DEPTH-1]),
        .i_side  (r_side[DEPTH-1]),
        .i_cfg   (r_cfg),
        .i_qx    (w_qx),
        .i_qy    (w_qy),
        .i_qz    (w_qz),
        .i_qa    (w_qa),
        .o_valid (o_valid),
        .o_data  (o_data)
    );

    assign o_busy      = r_busy;
    assign o_cfg_ready = r_cfg_ready;

`ifndef SYNTHESIS
    a_item_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##(DEPTH+1) o_valid)
        else $error("accepted item produced no result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, DEPTH+1))
        else $error("result without a matching accepted item");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && o_busy && !o_cfg_ready))
        else $error("outputs active right after reset");
`endif

endmodule

// ===== test/alpha_over_pixel_blend_top_test.sv =====
// Self-checking testbench for alpha_over_pixel_blend_top: drives pixel pairs and
// register writes, predicts straight-alpha over results and checks each output item.
// Depends on aopb_pkg and the alpha_over_pixel_blend_top RTL.
module alpha_over_pixel_blend_top_test;
    import aopb_pkg::*;

    localparam int STALL_LIMIT  = 1000;
    localparam int PIPE_LATENCY = COMP_BITS + 4;
    localparam int PHASE_ITEMS  = 112;
    localparam t_cfg_idx CFG_UNUSED = t_cfg_idx'(2);

    class over_blend_scoreboard;
        t_out        expected_pixels[$];
        logic        blend_on;
        logic        three_on;
        int unsigned fail_count;

        function new();
            blend_on   = 1'b1;
            three_on   = 1'b1;
            fail_count = 0;
        endfunction

        function void write_reg(t_cfg_idx idx, logic v);
            if (idx == CFG_BLEND_ENABLE) begin
                blend_on = v;
            end else if (idx == CFG_THREE_COMPONENTS) begin
                three_on = v;
            end
        endfunction

        function t_out predict_over(t_in p);
            logic [63:0] m, sx, sy, sz, sa, dx, dy, dz, da;
            logic [63:0] inv, a, wi, wo, ox, oy, oz, oa;
            t_out r;
            m  = (64'd1 << COMP_BITS) - 64'd1;
            sx = p.src_x & m;  sy = p.src_y & m;  sz = p.src_z & m;  sa = p.src_a & m;
            dx = p.dst_x & m;  dy = p.dst_y & m;  dz = p.dst_z & m;  da = p.dst_a & m;
            if (blend_on) begin
                inv = m - sa;
                a   = m * m - (m - da) * inv;
                ox  = 0;
                oy  = 0;
                oz  = 0;
                oa  = 0;
                if (a != 0) begin
                    wi = sa * m;
                    wo = da * inv;
                    ox = (sx * wi + dx * wo) / a;
                    oy = (sy * wi + dy * wo) / a;
                    oz = (sz * wi + dz * wo) / a;
                    oa = a / m;
                end
                if (!three_on) begin
                    oy = dy;
                    oz = dz;
                end
            end else begin
                ox = sx;
                oy = three_on ? sy : dy;
                oz = three_on ? sz : dz;
                oa = da;
            end
            r.out_x = ox[FIELD_W-1:0];
            r.out_y = oy[FIELD_W-1:0];
            r.out_z = oz[FIELD_W-1:0];
            r.out_a = oa[FIELD_W-1:0];
            return r;
        endfunction

        function void note_source(t_in p);
            expected_pixels.push_back(predict_over(p));
        endfunction

        function void cmp_field(string name, t_field exp_v, t_field act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
                fail_count++;
            end
        endfunction

        function void check_blended(t_out got);
            t_out want;
            if (expected_pixels.size() == 0) begin
                $error("unexpected output item: %h", got);
                fail_count++;
            end else begin
                want = expected_pixels.pop_front();
                cmp_field("out_x", want.out_x, got.out_x);
                cmp_field("out_y", want.out_y, got.out_y);
                cmp_field("out_z", want.out_z, got.out_z);
                cmp_field("out_a", want.out_a, got.out_a);
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    logic     i_clk;
    logic     i_rst_n;
    logic     i_start;
    logic     o_busy;
    t_in      i_data;
    logic     o_valid;
    t_out     o_data;
    logic     i_cfg_valid;
    logic     o_cfg_ready;
    t_cfg_idx i_cfg_index;
    logic     i_cfg_data;

    over_blend_scoreboard sb = new();
    int idle_cycles = 0;
    bit no_gaps = 1'b0;

    alpha_over_pixel_blend_top DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .o_busy     (o_busy),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .o_data     (o_data),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) begin
                sb.note_source(i_data);
            end
            if (o_valid) begin
                sb.check_blended(o_data);
            end
            if (i_cfg_valid && o_cfg_ready) begin
                sb.write_reg(i_cfg_index, i_cfg_data);
            end
        end
        if (i_rst_n && ((i_start && !o_busy) || o_valid || (i_cfg_valid && o_cfg_ready))) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("alpha_over_pixel_blend_top_test: errors");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (no_gaps || r < 65) begin
            return 0;
        end else if (r < 95) begin
            return $urandom_range(3, 1);
        end else begin
            return $urandom_range(40, 10);
        end
    endfunction

    function automatic t_field pick_comp();
        case ($urandom_range(7, 0))
            0:       return '0;
            1:       return '1;
            default: return t_field'($urandom_range(255, 0));
        endcase
    endfunction

    function automatic t_field pick_alpha();
        case ($urandom_range(7, 0))
            0, 1:    return '0;
            2, 3:    return '1;
            4:       return t_field'($urandom_range(2, 1));
            default: return t_field'($urandom_range(255, 0));
        endcase
    endfunction

    function automatic t_in random_pixel();
        t_in p;
        p.src_x = pick_comp();
        p.src_y = pick_comp();
        p.src_z = pick_comp();
        p.src_a = pick_alpha();
        p.dst_x = pick_comp();
        p.dst_y = pick_comp();
        p.dst_z = pick_comp();
        p.dst_a = pick_alpha();
        return p;
    endfunction

    task automatic send_pixel(input t_in px, input int gap);
        @(negedge i_clk);
        i_data  = px;
        i_start = 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        if (gap > 0) begin
            @(negedge i_clk);
            i_start = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_start = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic v);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic random_burst(input int count, input bit mid_drain);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(29, 0) == 0) begin
                no_gaps = !no_gaps;
            end
            if (mid_drain && k == count / 2) begin
                drain();
            end
            send_pixel(random_pixel(), pick_gap());
        end
        no_gaps = 1'b0;
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_start     = 1'b0;
        i_data      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_BLEND_ENABLE;
        i_cfg_data  = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // corners under the reset configuration
        send_pixel(t_in'({8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0}), 0);
        send_pixel(t_in'({8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}), 0);
        send_pixel(t_in'({8'd200, 8'd100, 8'd50, 8'd0, 8'd10, 8'd20, 8'd30, 8'd0}), 1);
        send_pixel(t_in'({8'd200, 8'd100, 8'd50, 8'd255, 8'd10, 8'd20, 8'd30, 8'd0}), 0);
        send_pixel(t_in'({8'd200, 8'd100, 8'd50, 8'd0, 8'd10, 8'd20, 8'd30, 8'd255}), 0);
        send_pixel(t_in'({8'd255, 8'd0, 8'd255, 8'd1, 8'd0, 8'd255, 8'd0, 8'd0}), 2);
        send_pixel(t_in'({8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd255, 8'd1}), 0);
        send_pixel(t_in'({8'd255, 8'd255, 8'd255, 8'd1, 8'd255, 8'd255, 8'd255, 8'd1}), 0);
        send_pixel(t_in'({8'd128, 8'd64, 8'd192, 8'd128, 8'd32, 8'd224, 8'd16, 8'd128}), 0);
        send_pixel(t_in'({8'd170, 8'd85, 8'd1, 8'd254, 8'd85, 8'd170, 8'd254, 8'd254}), 0);
        send_pixel(t_in'({8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}), 0);
        send_pixel(t_in'({8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255}), 0);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_BLEND_ENABLE, 1'b1);
                    write_reg(CFG_THREE_COMPONENTS, 1'b1);
                    write_reg(CFG_UNUSED, 1'b0);
                end
                1: begin
                    write_reg(CFG_BLEND_ENABLE, 1'b0);
                end
                2: begin
                    write_reg(CFG_BLEND_ENABLE, 1'b1);
                    write_reg(CFG_THREE_COMPONENTS, 1'b0);
                end
                default: begin
                    write_reg(CFG_BLEND_ENABLE, 1'b0);
                end
            endcase
            random_burst(PHASE_ITEMS, ph == 0);
            drain();
        end

        if (sb.pending() != 0) begin
            $error("%0d expected output items never arrived", sb.pending());
            sb.fail_count++;
        end
        if (sb.fail_count == 0) begin
            $display("alpha_over_pixel_blend_top_test: clean");
        end else begin
            $display("alpha_over_pixel_blend_top_test: errors");
        end
        $finish;
    end

endmodule

// ===== alpha_over_pixel_blend_top.f =====
hw/rtl/aopb_pkg.sv
hw/rtl/aopb_weight.sv
hw/rtl/aopb_lane.sv
hw/rtl/aopb_merge.sv
hw/rtl/alpha_over_pixel_blend_top.sv
test/alpha_over_pixel_blend_top_test.sv
